FILE: hw/rtl/invc_pkg.sv
`default_nettype none

package invc_pkg;

  localparam int unsigned MaxElements = 1024;
  localparam int unsigned AddrW       = $clog2(MaxElements);
  localparam int unsigned CntW        = $clog2(MaxElements + 1);
  localparam int unsigned ValueW      = 32;
  localparam int unsigned TotalW      = 19;

  localparam logic [ValueW-1:0] SignFlip = {1'b1, {(ValueW-1){1'b0}}};

  typedef struct packed {
    logic clr;
    logic issue;
  } scan_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/invc_if.sv
`default_nettype none

interface invc_in_if;
  import invc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;
  logic                     last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

interface invc_out_if;
  import invc_pkg::*;

  logic              valid;
  logic              ready;
  logic [TotalW-1:0] inversion_count;
  logic              overflow;

  modport source (output valid, inversion_count, overflow, input ready);
  modport sink   (input valid, inversion_count, overflow, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/invc_store.sv
`default_nettype none

module invc_store
  import invc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire logic [ValueW-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AddrW-1:0]  raddr_i,
  output      logic [ValueW-1:0] rdata_o
);

  logic [ValueW-1:0] mem_q [MaxElements];
  logic [ValueW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/invc_scan.sv
`default_nettype none

module invc_scan
  import invc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire scan_ctrl_t        ctrl_i,
  input  wire logic [ValueW-1:0] key_i,
  input  wire logic [ValueW-1:0] rdata_i,
  output      logic [CntW-1:0]   greater_o
);

  logic            valid_q;
  logic [CntW-1:0] greater_q, greater_d;

  // stored keys carry a flipped sign bit, so unsigned order is signed order
  always_comb begin
    greater_d = greater_q;
    if (ctrl_i.clr) begin
      greater_d = '0;
    end else if (valid_q && (rdata_i > key_i)) begin
      greater_d = greater_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      greater_q <= '0;
    end else begin
      valid_q   <= ctrl_i.issue;
      greater_q <= greater_d;
    end
  end

  assign greater_o = greater_q;

endmodule

`default_nettype wire

FILE: hw/rtl/inversion_counter.sv
`default_nettype none

// Inversion pair counter.
// in_i  : one signed 32-bit value per request, last marks the end of a sequence.
// out_o : one request per sequence, carrying the inversion count and an
//         overflow flag set when values beyond the 1024-entry store were dropped.
// Each value that fits in the store is compared with every value already stored, one
// stored entry a cycle through a single comparator reading the store's one read port.
// A request with values already stored passes through accept, a read of each stored
// entry, a wait for the registered read data and the update; the first value of a
// sequence goes through accept and update only, and a dropped value through accept.
// A request with last set then loads the output register, after which in_i is
// ready again.
// in_i is not ready while a value is being scanned.
// The output register holds a result until taken; a further last request is
// held until the register is free, so a stalled receiver stalls the input.
// Reset empties the sequence and drops any pending result; the store needs no
// clearing, since only entries below the fill count are read.

module inversion_counter
  import invc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  invc_in_if.sink   in_i,
  invc_out_if.source out_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StWait = 3'd2;
  localparam logic [2:0] StAdd  = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [ValueW-1:0] key_q, key_d;
  logic              last_q, last_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [TotalW-1:0] total_q, total_d;
  logic              drop_q, drop_d;
  logic              ovalid_q, ovalid_d;
  logic [TotalW-1:0] ocount_q, ocount_d;
  logic              oflow_q, oflow_d;

  scan_ctrl_t        ctrl;
  logic              we;
  logic [ValueW-1:0] rdata;
  logic [CntW-1:0]   greater;
  logic [AddrW-1:0]  last_idx;
  logic [TotalW:0]   sum;
  logic              accept;
  logic              oload;

  assign in_i.ready = (state_q == StIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign last_idx   = AddrW'(fill_q - CntW'(1));
  assign sum        = {1'b0, total_q} + (TotalW + 1)'(greater);
  assign oload      = !ovalid_q || out_o.ready;

  always_comb begin
    state_d    = state_q;
    key_d      = key_q;
    last_d     = last_q;
    fill_d     = fill_q;
    idx_d      = idx_q;
    total_d    = total_q;
    drop_d     = drop_q;
    ovalid_d   = ovalid_q;
    ocount_d   = ocount_q;
    oflow_d    = oflow_q;
    ctrl.clr   = 1'b0;
    ctrl.issue = 1'b0;
    we         = 1'b0;

    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          key_d    = ValueW'(in_i.value) ^ SignFlip;
          last_d   = in_i.last;
          idx_d    = '0;
          ctrl.clr = 1'b1;
          if (fill_q == CntW'(MaxElements)) begin
            drop_d  = 1'b1;
            state_d = in_i.last ? StEmit : StIdle;
          end else if (fill_q == '0) begin
            state_d = StAdd;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        ctrl.issue = 1'b1;
        idx_d      = idx_q + AddrW'(1);
        if (idx_q == last_idx) begin
          state_d = StWait;
        end
      end
      StWait: begin
        state_d = StAdd;
      end
      StAdd: begin
        we      = 1'b1;
        fill_d  = fill_q + CntW'(1);
        total_d = sum[TotalW] ? {TotalW{1'b1}} : sum[TotalW-1:0];
        state_d = last_q ? StEmit : StIdle;
      end
      StEmit: begin
        if (oload) begin
          ovalid_d = 1'b1;
          ocount_d = total_q;
          oflow_d  = drop_q;
          fill_d   = '0;
          total_d  = '0;
          drop_d   = 1'b0;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      last_q   <= 1'b0;
      fill_q   <= '0;
      idx_q    <= '0;
      total_q  <= '0;
      drop_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      last_q   <= last_d;
      fill_q   <= fill_d;
      idx_q    <= idx_d;
      total_q  <= total_d;
      drop_q   <= drop_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    ocount_q <= ocount_d;
    oflow_q  <= oflow_d;
  end

  invc_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (fill_q[AddrW-1:0]),
    .wdata_i (key_q),
    .re_i    (ctrl.issue),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  invc_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .key_i     (key_q),
    .rdata_i   (rdata),
    .greater_o (greater)
  );

  assign out_o.valid           = ovalid_q;
  assign out_o.inversion_count = ocount_q;
  assign out_o.overflow        = oflow_q;

endmodule

`default_nettype wire

FILE: bench/inversion_counter_test.sv
`default_nettype none

module inversion_counter_test;
  import invc_pkg::*;

  localparam int unsigned CountMax      = (1 << TotalW) - 1;
  localparam int unsigned FullTotal     = MaxElements * (MaxElements - 1) / 2;
  localparam int unsigned IdleLimit     = 20000;
  localparam int unsigned DrainCycles   = 1100;
  localparam int unsigned SqueezeCycles = 3000;
  localparam int unsigned RandomItems   = 580;
  localparam int unsigned NumRows       = 20;

  typedef struct packed {
    logic [TotalW-1:0] count;
    logic              ovf;
  } tally_t;

  typedef struct {
    logic signed [ValueW-1:0] value;
    logic                     last;
    bit                       typed;
    tally_t                   want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  invc_in_if  in_ch ();
  invc_out_if out_ch ();

  inversion_counter i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // sequence state of the predictor
  logic signed [ValueW-1:0] seen_vals [MaxElements];
  int unsigned              seen_fill;
  int unsigned              run_total;
  bit                       run_dropped;

  tally_t      tally_q [$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          calm;
  bit          squeeze_req;
  bit          squeeze_done;

  stim_row_t stim_rows [NumRows];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned gap_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [ValueW-1:0] draw_value(int unsigned mode);
    logic signed [ValueW-1:0] v;
    v = $urandom();
    case (mode)
      1: begin
        v = $signed($urandom_range(0, 8)) - 4;
      end
      2: begin
        case ($urandom_range(0, 6))
          0: v = 32'sh8000_0000;
          1: v = 32'sh8000_0001;
          2: v = -1;
          3: v = 0;
          4: v = 1;
          5: v = 32'sh7fff_fffe;
          default: v = 32'sh7fff_ffff;
        endcase
      end
      3: begin
        if ($urandom_range(0, 1) == 0) v = $signed($urandom_range(0, 16)) - 8;
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic stim_row_t row(logic signed [ValueW-1:0] v, logic lst, bit typed,
                                    int unsigned cnt, logic ovf);
    stim_row_t r;
    r.value      = v;
    r.last       = lst;
    r.typed      = typed;
    r.want.count = cnt[TotalW-1:0];
    r.want.ovf   = ovf;
    return r;
  endfunction

  task automatic tally_step(input logic signed [ValueW-1:0] v, input logic lst,
                            output tally_t res, output bit done_flag);
    int unsigned greater;
    greater   = 0;
    done_flag = 1'b0;
    res       = '0;
    if (seen_fill < MaxElements) begin
      for (int unsigned k = 0; k < seen_fill; k++) begin
        if (seen_vals[k] > v) greater++;
      end
      if (greater > CountMax - run_total) run_total = CountMax;
      else run_total += greater;
      seen_vals[seen_fill] = v;
      seen_fill++;
    end else begin
      run_dropped = 1'b1;
    end
    if (lst) begin
      res.count   = run_total[TotalW-1:0];
      res.ovf     = run_dropped;
      done_flag   = 1'b1;
      seen_fill   = 0;
      run_total   = 0;
      run_dropped = 1'b0;
    end
  endtask

  task automatic offer(input logic signed [ValueW-1:0] v, input logic lst, input bit typed,
                       input tally_t want);
    int unsigned g;
    tally_t      got;
    bit          done_flag;
    g = gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= lst;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    tally_step(v, lst, got, done_flag);
    if (done_flag) tally_q.push_back(typed ? want : got);
  endtask

  // receiver
  initial begin
    int unsigned stall;
    int unsigned squeeze;
    stall        = 0;
    squeeze      = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze != 0) begin
        out_ch.ready <= 1'b0;
        squeeze--;
      end else if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        squeeze      = SqueezeCycles - 1;
        out_ch.ready <= 1'b0;
      end else if (stall != 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        stall = gap_len();
        out_ch.ready <= (stall == 0);
        if (stall != 0) stall--;
      end
    end
  end

  // result check
  always @(posedge clk) begin
    tally_t head;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (tally_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, count %0d overflow %0b", $time,
                 out_ch.inversion_count, out_ch.overflow);
      end else begin
        head = tally_q.pop_front();
        if (out_ch.inversion_count !== head.count) begin
          mismatches++;
          $display("%0t: inversion count expected %0d, actual %0d", $time, head.count,
                   out_ch.inversion_count);
        end
        if (out_ch.overflow !== head.ovf) begin
          mismatches++;
          $display("%0t: overflow expected %0b, actual %0b", $time, head.ovf,
                   out_ch.overflow);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned mode;
    int unsigned pick;
    longint      lv;
    tally_t      want;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    in_ch.last   = 1'b0;
    calm         = 1'b0;
    squeeze_req  = 1'b0;
    squeeze_done = 1'b0;
    mismatches   = 0;
    idle_cycles  = 0;
    seen_fill    = 0;
    run_total    = 0;
    run_dropped  = 1'b0;
    for (int unsigned k = 0; k < MaxElements; k++) seen_vals[k] = '0;

    // lone item, simple pair, equal pair, ascending extremes, mixed, bit patterns, descent
    stim_rows[0]  = row(32'sh8000_0000, 1'b1, 1'b1, 0, 1'b0);
    stim_rows[1]  = row(32'sh7fff_ffff, 1'b0, 1'b0, 0, 1'b0);
    stim_rows[2]  = row(32'sh8000_0000, 1'b1, 1'b1, 1, 1'b0);
    stim_rows[3]  = row(5,              1'b0, 1'b0, 0, 1'b0);
    stim_rows[4]  = row(5,              1'b1, 1'b1, 0, 1'b0);
    stim_rows[5]  = row(32'sh8000_0000, 1'b0, 1'b0, 0, 1'b0);
    stim_rows[6]  = row(32'sh7fff_ffff, 1'b1, 1'b1, 0, 1'b0);
    stim_rows[7]  = row(-1,             1'b0, 1'b0, 0, 1'b0);
    stim_rows[8]  = row(0,              1'b0, 1'b0, 0, 1'b0);
    stim_rows[9]  = row(1,              1'b0, 1'b0, 0, 1'b0);
    stim_rows[10] = row(-1,             1'b1, 1'b0, 0, 1'b0);
    stim_rows[11] = row(32'shffff_ffff, 1'b0, 1'b0, 0, 1'b0);
    stim_rows[12] = row(32'sh0000_0001, 1'b0, 1'b0, 0, 1'b0);
    stim_rows[13] = row(32'sh8000_0001, 1'b0, 1'b0, 0, 1'b0);
    stim_rows[14] = row(32'sh7fff_fffe, 1'b0, 1'b0, 0, 1'b0);
    stim_rows[15] = row(32'sh5555_5555, 1'b0, 1'b0, 0, 1'b0);
    stim_rows[16] = row(32'shaaaa_aaaa, 1'b1, 1'b0, 0, 1'b0);
    stim_rows[17] = row(3,              1'b0, 1'b0, 0, 1'b0);
    stim_rows[18] = row(2,              1'b0, 1'b0, 0, 1'b0);
    stim_rows[19] = row(1,              1'b1, 1'b1, 3, 1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      offer(stim_rows[i].value, stim_rows[i].last, stim_rows[i].typed, stim_rows[i].want);
    end

    // strictly falling run that fills the store, then a dropped value and a dropped last
    for (int unsigned k = 0; k <= MaxElements; k++) begin
      lv = 64'sh7fff_ffff - longint'(k) * 64'sh40_0000 - longint'($urandom_range(0, 32'h3f_ffff));
      offer(lv[ValueW-1:0], 1'b0, 1'b0, '0);
    end
    want.count = FullTotal[TotalW-1:0];
    want.ovf   = 1'b1;
    offer(draw_value(0), 1'b1, 1'b1, want);

    sent = 0;
    while (sent < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) len = $urandom_range(1, 12);
      else if (pick < 95) len = $urandom_range(13, 40);
      else len = $urandom_range(41, 90);
      mode = $urandom_range(0, 3);
      calm = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < len; i++) begin
        offer(draw_value(mode), (i == len - 1), 1'b0, '0);
      end
      sent += len;
      if (sent >= 120) squeeze_req = 1'b1;
    end
    in_ch.valid <= 1'b0;

    while (tally_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0 && tally_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
